### design/ppia_pkg.sv
`default_nettype none

package ppia_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CTL_W  = 6;

  // control register bits
  localparam int unsigned CTL_IRQ_EN    = 0;
  localparam int unsigned CTL_RISING    = 1;
  localparam int unsigned CTL_SEL_OUT   = 2;
  localparam int unsigned CTL_C2_LEVEL  = 3;
  localparam int unsigned CTL_C2_MANUAL = 4;
  localparam int unsigned CTL_C2_OUT    = 5;

  localparam logic [2:0] C2_MODE_MANUAL_LOW  = 3'b110;
  localparam logic [2:0] C2_MODE_MANUAL_HIGH = 3'b111;
  localparam logic [1:0] C2_MODE_STROBE      = 2'b10;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_CA1   = 3'd2,
    KIND_CB1   = 3'd3,
    KIND_PINS  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OFF_DATA_A = 2'd0,
    OFF_CTL_A  = 2'd1,
    OFF_DATA_B = 2'd2,
    OFF_CTL_B  = 2'd3
  } offset_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_a;
    logic              irq_b;
    logic              ca2_level;
    logic              cb2_level;
    logic [DATA_W-1:0] port_a_drive;
    logic [DATA_W-1:0] port_b_drive;
  } result_t;

  function automatic logic c2_strobe(input logic [CTL_W-1:0] c);
    c2_strobe = (c[CTL_C2_OUT:CTL_C2_MANUAL] == C2_MODE_STROBE);
  endfunction

  function automatic logic c1_restore(input logic [CTL_W-1:0] c);
    c1_restore = ~c[CTL_C2_LEVEL];
  endfunction

endpackage

`default_nettype wire

### design/parallel_port_interface_adapter.sv
// Channel | Direction | Handshake            | Beat payload
// input   | in        | in_valid / in_stall   | kind, offset, write_data, line_level, port_a_pins
// output  | out       | out_valid / out_stall | read_data, irq_a, irq_b, ca2_level, cb2_level,
//         |           |                       | port_a_drive, port_b_drive
//
// One beat in per cycle while in_stall is low; a result is registered as its beat is
// accepted, or waits in the skid entry behind the held result while the output is stalled.
// Register state updates in the accept cycle, so back-to-back beats see it at once.
// A two-entry output buffer (result register plus skid) holds one extra result while stalled;
// in_stall rises only when both entries are full.
// Reset (rst, synchronous) empties the output buffer and sets all port registers
// to zero, with the CA1 last-seen level at one.
`default_nettype none

module parallel_port_interface_adapter (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   kind,
  input  wire logic [1:0]                   offset,
  input  wire logic [ppia_pkg::DATA_W-1:0]  write_data,
  input  wire logic                         line_level,
  input  wire logic [ppia_pkg::DATA_W-1:0]  port_a_pins,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ppia_pkg::DATA_W-1:0]       read_data,
  output logic                              irq_a,
  output logic                              irq_b,
  output logic                              ca2_level,
  output logic                              cb2_level,
  output logic [ppia_pkg::DATA_W-1:0]       port_a_drive,
  output logic [ppia_pkg::DATA_W-1:0]       port_b_drive
);

  logic [ppia_pkg::CTL_W-1:0]  control_a, control_a_next;
  logic [ppia_pkg::CTL_W-1:0]  control_b, control_b_next;
  logic [ppia_pkg::DATA_W-1:0] direction_a, direction_a_next;
  logic [ppia_pkg::DATA_W-1:0] direction_b, direction_b_next;
  logic [ppia_pkg::DATA_W-1:0] latch_a, latch_a_next;
  logic [ppia_pkg::DATA_W-1:0] latch_b, latch_b_next;
  logic [ppia_pkg::DATA_W-1:0] pins_b, pins_b_next;
  logic ca1_seen, ca1_seen_next;
  logic cb1_seen, cb1_seen_next;
  logic ca2_out, ca2_out_next;
  logic cb2_out, cb2_out_next;
  logic flag_a1, flag_a1_next;
  logic flag_b1, flag_b1_next;
  logic [ppia_pkg::DATA_W-1:0] rd_next;

  ppia_pkg::result_t result, skid, result_next;
  logic skid_valid;
  logic in_accept;
  logic out_take;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~skid_valid;
  assign out_take  = out_valid & ~out_stall;

  always_comb begin
    control_a_next   = control_a;
    control_b_next   = control_b;
    direction_a_next = direction_a;
    direction_b_next = direction_b;
    latch_a_next     = latch_a;
    latch_b_next     = latch_b;
    pins_b_next      = pins_b;
    ca1_seen_next    = ca1_seen;
    cb1_seen_next    = cb1_seen;
    ca2_out_next     = ca2_out;
    cb2_out_next     = cb2_out;
    flag_a1_next     = flag_a1;
    flag_b1_next     = flag_b1;
    rd_next          = '0;

    case (kind)
      ppia_pkg::KIND_READ: begin
        case (offset)
          ppia_pkg::OFF_DATA_A: begin
            if (!control_a[ppia_pkg::CTL_SEL_OUT]) begin
              rd_next = direction_a;
            end else begin
              rd_next = (latch_a & direction_a) | (port_a_pins & ~direction_a);
              flag_a1_next = 1'b0;
              if (ppia_pkg::c2_strobe(control_a) && ppia_pkg::c1_restore(control_a)) begin
                ca2_out_next = 1'b1;
              end
            end
          end
          ppia_pkg::OFF_CTL_A: begin
            rd_next = {flag_a1, 1'b0, control_a};
          end
          ppia_pkg::OFF_DATA_B: begin
            if (!control_b[ppia_pkg::CTL_SEL_OUT]) begin
              rd_next = direction_b;
            end else begin
              rd_next = (latch_b & direction_b) | (pins_b & ~direction_b);
              if (flag_b1 && ppia_pkg::c2_strobe(control_b)
                  && ppia_pkg::c1_restore(control_b)) begin
                cb2_out_next = 1'b1;
              end
              flag_b1_next = 1'b0;
            end
          end
          default: begin
            rd_next = {flag_b1, 1'b0, control_b};
          end
        endcase
      end
      ppia_pkg::KIND_WRITE: begin
        case (offset)
          ppia_pkg::OFF_DATA_A: begin
            if (!control_a[ppia_pkg::CTL_SEL_OUT]) begin
              direction_a_next = write_data;
            end else begin
              latch_a_next = write_data;
              if (ppia_pkg::c2_strobe(control_a)) begin
                ca2_out_next = 1'b0;
              end
            end
          end
          ppia_pkg::OFF_CTL_A: begin
            control_a_next = write_data[ppia_pkg::CTL_W-1:0];
            if (write_data[ppia_pkg::CTL_C2_OUT]) begin
              if (write_data[5:3] == ppia_pkg::C2_MODE_MANUAL_LOW) begin
                ca2_out_next = 1'b0;
              end else if (write_data[5:3] == ppia_pkg::C2_MODE_MANUAL_HIGH) begin
                ca2_out_next = 1'b1;
              end
            end else if (control_a[ppia_pkg::CTL_C2_OUT]) begin
              ca2_out_next = 1'b0;
            end
          end
          ppia_pkg::OFF_DATA_B: begin
            if (!control_b[ppia_pkg::CTL_SEL_OUT]) begin
              direction_b_next = write_data;
            end else begin
              latch_b_next = write_data;
              if (ppia_pkg::c2_strobe(control_b)) begin
                cb2_out_next = 1'b0;
              end
            end
          end
          default: begin
            control_b_next = write_data[ppia_pkg::CTL_W-1:0];
            if (write_data[ppia_pkg::CTL_C2_OUT]) begin
              if (write_data[5:3] == ppia_pkg::C2_MODE_MANUAL_LOW) begin
                cb2_out_next = 1'b0;
              end else if (write_data[5:3] == ppia_pkg::C2_MODE_MANUAL_HIGH) begin
                cb2_out_next = 1'b1;
              end
            end else if (control_b[ppia_pkg::CTL_C2_OUT]) begin
              cb2_out_next = 1'b0;
            end
          end
        endcase
      end
      ppia_pkg::KIND_CA1: begin
        if (line_level != ca1_seen) begin
          if (line_level == control_a[ppia_pkg::CTL_RISING]) begin
            flag_a1_next = 1'b1;
            if (ppia_pkg::c2_strobe(control_a) && !ppia_pkg::c1_restore(control_a)) begin
              ca2_out_next = 1'b1;
            end
          end
          ca1_seen_next = line_level;
        end
      end
      ppia_pkg::KIND_CB1: begin
        if (line_level != cb1_seen) begin
          if (line_level == control_b[ppia_pkg::CTL_RISING]) begin
            flag_b1_next = 1'b1;
          end
          cb1_seen_next = line_level;
        end
      end
      ppia_pkg::KIND_PINS: begin
        pins_b_next = write_data;
      end
      default: begin
      end
    endcase

    result_next.read_data    = rd_next;
    result_next.irq_a        = flag_a1_next & control_a_next[ppia_pkg::CTL_IRQ_EN];
    result_next.irq_b        = flag_b1_next & control_b_next[ppia_pkg::CTL_IRQ_EN];
    result_next.ca2_level    = ca2_out_next;
    result_next.cb2_level    = cb2_out_next;
    result_next.port_a_drive = latch_a_next & direction_a_next;
    result_next.port_b_drive = latch_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_a   <= '0;
      control_b   <= '0;
      direction_a <= '0;
      direction_b <= '0;
      latch_a     <= '0;
      latch_b     <= '0;
      pins_b      <= '0;
      ca1_seen    <= 1'b1;
      cb1_seen    <= 1'b0;
      ca2_out     <= 1'b0;
      cb2_out     <= 1'b0;
      flag_a1     <= 1'b0;
      flag_b1     <= 1'b0;
    end else if (in_accept) begin
      control_a   <= control_a_next;
      control_b   <= control_b_next;
      direction_a <= direction_a_next;
      direction_b <= direction_b_next;
      latch_a     <= latch_a_next;
      latch_b     <= latch_b_next;
      pins_b      <= pins_b_next;
      ca1_seen    <= ca1_seen_next;
      cb1_seen    <= cb1_seen_next;
      ca2_out     <= ca2_out_next;
      cb2_out     <= cb2_out_next;
      flag_a1     <= flag_a1_next;
      flag_b1     <= flag_b1_next;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid || !out_stall) begin
        result    <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid       <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign read_data    = result.read_data;
  assign irq_a        = result.irq_a;
  assign irq_b        = result.irq_b;
  assign ca2_level    = result.ca2_level;
  assign cb2_level    = result.cb2_level;
  assign port_a_drive = result.port_a_drive;
  assign port_b_drive = result.port_b_drive;

`ifndef NO_ASSERTIONS
  a_skid_needs_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_latch_a_write: assert property (@(posedge clk) disable iff (rst)
    (in_accept && kind == ppia_pkg::KIND_WRITE && offset == ppia_pkg::OFF_DATA_A
     && control_a[ppia_pkg::CTL_SEL_OUT]) |=> latch_a == $past(write_data))
    else $error("port A latch write lost");
`endif

endmodule

`default_nettype wire
